FILE: sv/lldc_pkg.sv
// lldc_pkg: shared widths, codes and item types of the least-loaded capped dispatcher
`default_nettype none
package lldc_pkg;

    // sizes
    localparam int MAX_WORKERS = 256;
    localparam int WORKER_W    = 8;
    localparam int WCOUNT_W    = 9;
    localparam int LOAD_W      = 10;
    localparam int DONE_W      = 9;
    localparam int COUNT_W     = 32;
    localparam int CFG_DATA_W  = 10;
    localparam int CFG_IDX_W   = 1;

    // operation codes
    localparam logic [1:0] OP_DISPATCH = 2'd0;
    localparam logic [1:0] OP_COMPLETE = 2'd1;
    localparam logic [1:0] OP_START    = 2'd2;
    localparam logic [1:0] OP_LOST     = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BUSY     = 2'd1;
    localparam logic [1:0] ST_CLAMPED  = 2'd2;
    localparam logic [1:0] ST_NOT_LIVE = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WORKER_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_LIMIT   = 1'd1;

    // input item
    typedef struct packed {
        logic [1:0]          op;
        logic [WORKER_W-1:0] worker_id;
        logic [DONE_W-1:0]   done_count;
    } in_item_t;

    // result item
    typedef struct packed {
        logic                granted;
        logic [WORKER_W-1:0] chosen_worker;
        logic [1:0]          status;
        logic [LOAD_W-1:0]   worker_load;
        logic                accept_open;
        logic [WCOUNT_W-1:0] live_workers;
        logic [COUNT_W-1:0]  total_dispatched;
        logic [COUNT_W-1:0]  total_rejected;
    } out_item_t;

    // one worker entry of the state memory
    typedef struct packed {
        logic                alive;
        logic [LOAD_W-1:0]   load;
    } entry_t;

endpackage
`default_nettype wire

FILE: sv/lldc_load_ram.sv
// lldc_load_ram: per-worker live bit and in-flight count memory, one write and one registered read port
`default_nettype none
module lldc_load_ram (
    input  wire logic                              clk,
    input  wire logic                              we,
    input  wire logic [lldc_pkg::WORKER_W-1:0]     waddr,
    input  wire lldc_pkg::entry_t                  wdata,
    input  wire logic [lldc_pkg::WORKER_W-1:0]     raddr,
    output lldc_pkg::entry_t                       rdata
);

    lldc_pkg::entry_t mem [lldc_pkg::MAX_WORKERS];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

FILE: sv/least_loaded_capped_dispatcher.sv
// least_loaded_capped_dispatcher: top level, request sequencer around the worker memory
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+-----------------------------
//   in      | input     | in_valid / in_stall      | in_data  (lldc_pkg::in_item_t)
//   out     | output    | out_valid / out_stall    | out_data (lldc_pkg::out_item_t)
//   cfg     | input     | cfg_we (no wait)         | cfg_index, cfg_data
//
// below, worker_count means the effective count (zero acts as 1, capped at 256)
// a dispatch does one memory read per worker entry to find the least loaded one,
// then the grant write and the result load
// other items do a read-modify-write of the addressed entry, then the same scan over
// the entries in use to rebuild the listener gate
// the result sits in an output register; the next item is taken while it waits
// reset starts a clearing pass over all 256 entries; in_stall is held until it ends
// writing worker_count starts a sweep that reads and clears the entries at and above
// it, one per cycle; in_stall is held until the sweep ends
`default_nettype none
module least_loaded_capped_dispatcher (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire lldc_pkg::in_item_t                    in_data,
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output lldc_pkg::out_item_t                        out_data,
    input  wire logic                                  cfg_we,
    input  wire logic [lldc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [lldc_pkg::CFG_DATA_W-1:0]       cfg_data
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_READ   = 6'b000010,
        S_MODIFY = 6'b000100,
        S_SCAN   = 6'b001000,
        S_GRANT  = 6'b010000,
        S_EMIT   = 6'b100000
    } state_t;

    localparam logic [lldc_pkg::WCOUNT_W-1:0] WC_MAX  = lldc_pkg::WCOUNT_W'(lldc_pkg::MAX_WORKERS);
    localparam logic [lldc_pkg::COUNT_W-1:0]  CNT_MAX = '1;

    state_t                             state_reg, state_next;
    logic [lldc_pkg::WCOUNT_W-1:0]      wc_reg;
    logic [lldc_pkg::LOAD_W-1:0]        sl_reg;
    logic [1:0]                         op_reg, op_next;
    logic [lldc_pkg::WORKER_W-1:0]      id_reg, id_next;
    logic [lldc_pkg::DONE_W-1:0]        done_reg, done_next;
    logic [lldc_pkg::WCOUNT_W-1:0]      live_reg, live_next;
    logic [lldc_pkg::COUNT_W-1:0]       disp_reg, disp_next;
    logic [lldc_pkg::COUNT_W-1:0]       rej_reg, rej_next;
    logic [lldc_pkg::WCOUNT_W-1:0]      sweep_idx_reg, sweep_idx_next;
    logic                               sweep_pv_reg, sweep_pv_next;
    logic [lldc_pkg::WORKER_W-1:0]      sweep_addr_reg, sweep_addr_next;
    logic [lldc_pkg::WCOUNT_W-1:0]      scan_idx_reg, scan_idx_next;
    logic                               pv_reg, pv_next;
    logic [lldc_pkg::WORKER_W-1:0]      pidx_reg, pidx_next;
    logic                               found_reg, found_next;
    logic [lldc_pkg::WORKER_W-1:0]      best_reg, best_next;
    logic [lldc_pkg::LOAD_W-1:0]        best_val_reg, best_val_next;
    logic [1:0]                         elig_cnt_reg, elig_cnt_next;
    logic                               granted_reg, granted_next;
    logic [lldc_pkg::WORKER_W-1:0]      chosen_reg, chosen_next;
    logic [1:0]                         status_reg, status_next;
    logic [lldc_pkg::LOAD_W-1:0]        load_reg, load_next;
    logic                               open_reg, open_next;
    logic                               out_valid_reg, out_valid_next;
    lldc_pkg::out_item_t                out_data_reg, out_data_next;

    logic                               mem_we;
    logic [lldc_pkg::WORKER_W-1:0]      mem_waddr;
    lldc_pkg::entry_t                   mem_wdata;
    logic [lldc_pkg::WORKER_W-1:0]      mem_raddr;
    lldc_pkg::entry_t                   mem_rdata;

    logic [lldc_pkg::WCOUNT_W-1:0]      nw;
    logic [lldc_pkg::LOAD_W-1:0]        slots;
    logic [lldc_pkg::WCOUNT_W-1:0]      cfg_w;
    logic                               accept;
    logic [lldc_pkg::LOAD_W-1:0]        cur_v;
    logic                               elig;
    logic                               id_ok;
    logic                               id_alive;
    logic [lldc_pkg::LOAD_W-1:0]        id_load;
    logic [lldc_pkg::LOAD_W-1:0]        done_ext;
    logic [lldc_pkg::LOAD_W-1:0]        grant_load;

    // effective configuration
    always_comb
    begin
        nw = wc_reg;
        if (wc_reg == '0)
        begin
            nw = lldc_pkg::WCOUNT_W'(1);
        end
        else if (wc_reg > WC_MAX)
        begin
            nw = WC_MAX;
        end
        slots = (sl_reg == '0) ? lldc_pkg::LOAD_W'(1) : sl_reg;
        cfg_w = cfg_data[lldc_pkg::WCOUNT_W-1:0];
        if (cfg_w == '0)
        begin
            cfg_w = lldc_pkg::WCOUNT_W'(1);
        end
        else if (cfg_w > WC_MAX)
        begin
            cfg_w = WC_MAX;
        end
    end

    // input handshake
    assign in_stall = !((state_reg == S_IDLE) && sweep_idx_reg[lldc_pkg::WCOUNT_W-1]
                        && !sweep_pv_reg);
    assign accept   = in_valid && !in_stall;

    // scan data and addressed entry views, dead entries hold a zero count
    assign cur_v      = mem_rdata.load;
    assign elig       = mem_rdata.alive && (cur_v < slots);
    assign id_ok      = {1'b0, id_reg} < nw;
    assign id_alive   = mem_rdata.alive;
    assign id_load    = mem_rdata.load;
    assign done_ext   = {1'b0, done_reg};
    assign grant_load = best_val_reg + lldc_pkg::LOAD_W'(1);

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        id_next         = id_reg;
        done_next       = done_reg;
        live_next       = live_reg;
        disp_next       = disp_reg;
        rej_next        = rej_reg;
        sweep_idx_next  = sweep_idx_reg;
        sweep_pv_next   = 1'b0;
        sweep_addr_next = sweep_addr_reg;
        scan_idx_next   = scan_idx_reg;
        pv_next         = 1'b0;
        pidx_next       = pidx_reg;
        found_next      = found_reg;
        best_next       = best_reg;
        best_val_next   = best_val_reg;
        elig_cnt_next   = elig_cnt_reg;
        granted_next    = granted_reg;
        chosen_next     = chosen_reg;
        status_next     = status_reg;
        load_next       = load_reg;
        open_next       = open_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        mem_we          = 1'b0;
        mem_waddr       = id_reg;
        mem_wdata       = '0;
        mem_raddr       = scan_idx_reg[lldc_pkg::WORKER_W-1:0];

        // clear entries after reset or above a written worker count: read, then write back zero
        if (!sweep_idx_reg[lldc_pkg::WCOUNT_W-1])
        begin
            mem_raddr       = sweep_idx_reg[lldc_pkg::WORKER_W-1:0];
            sweep_pv_next   = 1'b1;
            sweep_addr_next = sweep_idx_reg[lldc_pkg::WORKER_W-1:0];
            sweep_idx_next  = sweep_idx_reg + lldc_pkg::WCOUNT_W'(1);
        end
        if (sweep_pv_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = sweep_addr_reg;
            mem_wdata = '0;
            if (mem_rdata.alive && (live_reg != '0))
            begin
                live_next = live_reg - lldc_pkg::WCOUNT_W'(1);
            end
        end
        if (cfg_we && (cfg_index == lldc_pkg::CFG_WORKER_COUNT))
        begin
            sweep_idx_next = (cfg_w < sweep_idx_reg) ? cfg_w : sweep_idx_reg;
        end

        // output register drains
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next       = in_data.op;
                    id_next       = in_data.worker_id;
                    done_next     = in_data.done_count;
                    scan_idx_next = '0;
                    found_next    = 1'b0;
                    elig_cnt_next = '0;
                    state_next    = (in_data.op == lldc_pkg::OP_DISPATCH) ? S_SCAN : S_READ;
                end
            end

            S_READ:
            begin
                mem_raddr  = id_reg;
                state_next = S_MODIFY;
            end

            S_MODIFY:
            begin
                granted_next = 1'b0;
                chosen_next  = id_reg;
                status_next  = lldc_pkg::ST_OK;
                load_next    = '0;
                if (!id_ok)
                begin
                    status_next = lldc_pkg::ST_NOT_LIVE;
                end
                else
                begin
                    case (op_reg)
                        lldc_pkg::OP_COMPLETE:
                        begin
                            if (!id_alive)
                            begin
                                status_next = lldc_pkg::ST_NOT_LIVE;
                            end
                            else
                            begin
                                mem_we          = 1'b1;
                                mem_wdata.alive = 1'b1;
                                if (done_ext > id_load)
                                begin
                                    mem_wdata.load = '0;
                                    status_next    = lldc_pkg::ST_CLAMPED;
                                end
                                else
                                begin
                                    mem_wdata.load = id_load - done_ext;
                                end
                                load_next = mem_wdata.load;
                            end
                        end
                        lldc_pkg::OP_START:
                        begin
                            if (!id_alive)
                            begin
                                live_next       = live_reg + lldc_pkg::WCOUNT_W'(1);
                                mem_we          = 1'b1;
                                mem_wdata.alive = 1'b1;
                                mem_wdata.load  = '0;
                            end
                            load_next = id_load;
                        end
                        lldc_pkg::OP_LOST:
                        begin
                            if (!id_alive)
                            begin
                                status_next = lldc_pkg::ST_NOT_LIVE;
                            end
                            else
                            begin
                                // entry goes dead with its count cleared
                                mem_we    = 1'b1;
                                mem_wdata = '0;
                                if (live_reg != '0)
                                begin
                                    live_next = live_reg - lldc_pkg::WCOUNT_W'(1);
                                end
                            end
                        end
                        default:
                        begin
                            status_next = status_reg;
                        end
                    endcase
                end
                state_next = S_SCAN;
            end

            S_SCAN:
            begin
                // issue one read per entry in use
                if (scan_idx_reg < nw)
                begin
                    pv_next       = 1'b1;
                    pidx_next     = scan_idx_reg[lldc_pkg::WORKER_W-1:0];
                    scan_idx_next = scan_idx_reg + lldc_pkg::WCOUNT_W'(1);
                end
                // evaluate the entry read last cycle
                if (pv_reg && elig)
                begin
                    if (elig_cnt_reg != 2'd2)
                    begin
                        elig_cnt_next = elig_cnt_reg + 2'd1;
                    end
                    if (!found_reg || (cur_v < best_val_reg))
                    begin
                        found_next    = 1'b1;
                        best_next     = pidx_reg;
                        best_val_next = cur_v;
                    end
                end
                // scan finished once nothing was issued or is in flight
                if (!(scan_idx_reg < nw) && !pv_reg)
                begin
                    if (op_reg == lldc_pkg::OP_DISPATCH)
                    begin
                        state_next = S_GRANT;
                    end
                    else
                    begin
                        open_next  = (elig_cnt_reg != '0);
                        state_next = S_EMIT;
                    end
                end
            end

            S_GRANT:
            begin
                if (found_reg)
                begin
                    mem_we          = 1'b1;
                    mem_waddr       = best_reg;
                    mem_wdata.alive = 1'b1;
                    mem_wdata.load  = grant_load;
                    granted_next    = 1'b1;
                    chosen_next     = best_reg;
                    status_next     = lldc_pkg::ST_OK;
                    load_next       = grant_load;
                    open_next       = (elig_cnt_reg == 2'd2) || (grant_load < slots);
                    if (disp_reg != CNT_MAX)
                    begin
                        disp_next = disp_reg + lldc_pkg::COUNT_W'(1);
                    end
                end
                else
                begin
                    granted_next = 1'b0;
                    chosen_next  = '0;
                    status_next  = lldc_pkg::ST_BUSY;
                    load_next    = '0;
                    open_next    = 1'b0;
                    if (rej_reg != CNT_MAX)
                    begin
                        rej_next = rej_reg + lldc_pkg::COUNT_W'(1);
                    end
                end
                state_next = S_EMIT;
            end

            S_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next                 = 1'b1;
                    out_data_next.granted          = granted_reg;
                    out_data_next.chosen_worker    = chosen_reg;
                    out_data_next.status           = status_reg;
                    out_data_next.worker_load      = load_reg;
                    out_data_next.accept_open      = open_reg;
                    out_data_next.live_workers     = live_reg;
                    out_data_next.total_dispatched = disp_reg;
                    out_data_next.total_rejected   = rej_reg;
                    state_next                     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wc_reg        <= lldc_pkg::WCOUNT_W'(1);
            sl_reg        <= lldc_pkg::LOAD_W'(1);
            live_reg      <= '0;
            disp_reg      <= '0;
            rej_reg       <= '0;
            sweep_idx_reg <= '0;
            sweep_pv_reg  <= 1'b0;
            pv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            live_reg      <= live_next;
            disp_reg      <= disp_next;
            rej_reg       <= rej_next;
            sweep_idx_reg <= sweep_idx_next;
            sweep_pv_reg  <= sweep_pv_next;
            pv_reg        <= pv_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we && (cfg_index == lldc_pkg::CFG_WORKER_COUNT))
            begin
                wc_reg <= cfg_data[lldc_pkg::WCOUNT_W-1:0];
            end
            if (cfg_we && (cfg_index == lldc_pkg::CFG_SLOT_LIMIT))
            begin
                sl_reg <= cfg_data[lldc_pkg::LOAD_W-1:0];
            end
        end
    end

    // payload and scan registers
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        id_reg         <= id_next;
        done_reg       <= done_next;
        sweep_addr_reg <= sweep_addr_next;
        scan_idx_reg   <= scan_idx_next;
        pidx_reg       <= pidx_next;
        found_reg      <= found_next;
        best_reg       <= best_next;
        best_val_reg   <= best_val_next;
        elig_cnt_reg   <= elig_cnt_next;
        granted_reg    <= granted_next;
        chosen_reg     <= chosen_next;
        status_reg     <= status_next;
        load_reg       <= load_next;
        open_reg       <= open_next;
        out_data_reg   <= out_data_next;
    end

    // worker memory: live bit and in-flight count
    lldc_load_ram u_load_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
`default_nettype wire

FILE: bench/least_loaded_capped_dispatcher_test.sv
// least_loaded_capped_dispatcher_test: self-checking bench with a dispatch predictor and random stalls
`timescale 1ns / 1ps
module least_loaded_capped_dispatcher_test;

    // cycles with no handshake at all before the run is declared hung
    localparam int WATCHDOG_LIMIT = 5000;
    // settle time after the last result, covers one full scan of all entries
    localparam int TAIL_CYCLES = 300;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    // one directed step: an item (with an optional typed result) or a register write
    typedef struct packed {
        row_kind_t                       kind;
        lldc_pkg::in_item_t              item;
        logic [lldc_pkg::CFG_IDX_W-1:0]  reg_index;
        logic [lldc_pkg::CFG_DATA_W-1:0] reg_value;
        logic                            typed;
        lldc_pkg::out_item_t             want;
    } plan_row_t;

    // one random phase: register settings and number of items
    typedef struct packed {
        logic [lldc_pkg::CFG_DATA_W-1:0] workers;
        logic [lldc_pkg::CFG_DATA_W-1:0] slots;
        logic [15:0]                     items;
    } phase_t;

    localparam int PLAN_ROWS = 28;
    localparam plan_row_t PLAN [PLAN_ROWS] = '{
        // nothing live after reset: rejects, not-live answers, id out of use
        '{ROW_ITEM, '{lldc_pkg::OP_DISPATCH, 8'd0, 9'd0}, '0, '0, 1'b1,
          '{1'b0, 8'd0, lldc_pkg::ST_BUSY, 10'd0, 1'b0, 9'd0, 32'd0, 32'd1}},
        '{ROW_ITEM, '{lldc_pkg::OP_COMPLETE, 8'd0, 9'd5}, '0, '0, 1'b1,
          '{1'b0, 8'd0, lldc_pkg::ST_NOT_LIVE, 10'd0, 1'b0, 9'd0, 32'd0, 32'd1}},
        '{ROW_ITEM, '{lldc_pkg::OP_LOST, 8'd0, 9'd0}, '0, '0, 1'b1,
          '{1'b0, 8'd0, lldc_pkg::ST_NOT_LIVE, 10'd0, 1'b0, 9'd0, 32'd0, 32'd1}},
        '{ROW_ITEM, '{lldc_pkg::OP_START, 8'd255, 9'd0}, '0, '0, 1'b1,
          '{1'b0, 8'd255, lldc_pkg::ST_NOT_LIVE, 10'd0, 1'b0, 9'd0, 32'd0, 32'd1}},
        // start, start again while live, fill the single slot, reject
        '{ROW_ITEM, '{lldc_pkg::OP_START, 8'd0, 9'd0}, '0, '0, 1'b1,
          '{1'b0, 8'd0, lldc_pkg::ST_OK, 10'd0, 1'b1, 9'd1, 32'd0, 32'd1}},
        '{ROW_ITEM, '{lldc_pkg::OP_START, 8'd0, 9'd0}, '0, '0, 1'b1,
          '{1'b0, 8'd0, lldc_pkg::ST_OK, 10'd0, 1'b1, 9'd1, 32'd0, 32'd1}},
        '{ROW_ITEM, '{lldc_pkg::OP_DISPATCH, 8'd255, 9'd511}, '0, '0, 1'b1,
          '{1'b1, 8'd0, lldc_pkg::ST_OK, 10'd1, 1'b0, 9'd1, 32'd1, 32'd1}},
        '{ROW_ITEM, '{lldc_pkg::OP_DISPATCH, 8'd0, 9'd0}, '0, '0, 1'b1,
          '{1'b0, 8'd0, lldc_pkg::ST_BUSY, 10'd0, 1'b0, 9'd1, 32'd1, 32'd2}},
        // over-report clamps, zero report, loss, loss of a dead worker
        '{ROW_ITEM, '{lldc_pkg::OP_COMPLETE, 8'd0, 9'd511}, '0, '0, 1'b1,
          '{1'b0, 8'd0, lldc_pkg::ST_CLAMPED, 10'd0, 1'b1, 9'd1, 32'd1, 32'd2}},
        '{ROW_ITEM, '{lldc_pkg::OP_COMPLETE, 8'd0, 9'd0}, '0, '0, 1'b1,
          '{1'b0, 8'd0, lldc_pkg::ST_OK, 10'd0, 1'b1, 9'd1, 32'd1, 32'd2}},
        '{ROW_ITEM, '{lldc_pkg::OP_LOST, 8'd0, 9'd0}, '0, '0, 1'b1,
          '{1'b0, 8'd0, lldc_pkg::ST_OK, 10'd0, 1'b0, 9'd0, 32'd1, 32'd2}},
        '{ROW_ITEM, '{lldc_pkg::OP_LOST, 8'd0, 9'd0}, '0, '0, 1'b1,
          '{1'b0, 8'd0, lldc_pkg::ST_NOT_LIVE, 10'd0, 1'b0, 9'd0, 32'd1, 32'd2}},
        // zero slot limit acts as one, all-ones worker count acts as the maximum
        '{ROW_CFG, '0, lldc_pkg::CFG_SLOT_LIMIT, 10'd0, 1'b0, '0},
        '{ROW_CFG, '0, lldc_pkg::CFG_WORKER_COUNT, 10'h3FF, 1'b0, '0},
        '{ROW_ITEM, '{lldc_pkg::OP_START, 8'd255, 9'd0}, '0, '0, 1'b0, '0},
        '{ROW_ITEM, '{lldc_pkg::OP_START, 8'd128, 9'd256}, '0, '0, 1'b0, '0},
        '{ROW_ITEM, '{lldc_pkg::OP_START, 8'd3, 9'h155}, '0, '0, 1'b0, '0},
        '{ROW_ITEM, '{lldc_pkg::OP_DISPATCH, 8'h55, 9'd0}, '0, '0, 1'b0, '0},
        '{ROW_ITEM, '{lldc_pkg::OP_DISPATCH, 8'hAA, 9'd0}, '0, '0, 1'b0, '0},
        '{ROW_ITEM, '{lldc_pkg::OP_DISPATCH, 8'd0, 9'd0}, '0, '0, 1'b0, '0},
        '{ROW_ITEM, '{lldc_pkg::OP_DISPATCH, 8'd0, 9'd0}, '0, '0, 1'b0, '0},
        '{ROW_ITEM, '{lldc_pkg::OP_COMPLETE, 8'd255, 9'd256}, '0, '0, 1'b0, '0},
        // widest slot limit, tie break, then shrink to one entry
        '{ROW_CFG, '0, lldc_pkg::CFG_SLOT_LIMIT, 10'd1023, 1'b0, '0},
        '{ROW_ITEM, '{lldc_pkg::OP_DISPATCH, 8'd0, 9'd0}, '0, '0, 1'b0, '0},
        '{ROW_ITEM, '{lldc_pkg::OP_LOST, 8'd3, 9'd0}, '0, '0, 1'b0, '0},
        '{ROW_CFG, '0, lldc_pkg::CFG_WORKER_COUNT, 10'd0, 1'b0, '0},
        '{ROW_ITEM, '{lldc_pkg::OP_DISPATCH, 8'd0, 9'd0}, '0, '0, 1'b0, '0},
        '{ROW_ITEM, '{lldc_pkg::OP_START, 8'd200, 9'd0}, '0, '0, 1'b0, '0}
    };

    localparam int PHASES = 10;
    localparam phase_t PHASE_LIST [PHASES] = '{
        '{10'd4, 10'd2, 16'd200},
        '{10'd8, 10'd1, 16'd180},
        '{10'd256, 10'd3, 16'd60},
        '{10'd2, 10'd0, 16'd120},
        '{10'd1, 10'd5, 16'd60},
        '{10'd16, 10'd4, 16'd200},
        '{10'd300, 10'd1, 16'd40},
        '{10'd5, 10'd1023, 16'd200},
        '{10'd12, 10'd2, 16'd180},
        '{10'd6, 10'd3, 16'd160}
    };

    logic                            clk;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_stall;
    lldc_pkg::in_item_t              in_data;
    logic                            out_valid;
    logic                            out_stall;
    lldc_pkg::out_item_t             out_data;
    logic                            cfg_we;
    logic [lldc_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [lldc_pkg::CFG_DATA_W-1:0] cfg_data;

    // predictor state
    logic [lldc_pkg::LOAD_W-1:0]   load_of [lldc_pkg::MAX_WORKERS];
    bit                            live_of [lldc_pkg::MAX_WORKERS];
    logic [lldc_pkg::WCOUNT_W-1:0] live_sum;
    logic [lldc_pkg::COUNT_W-1:0]  granted_sum;
    logic [lldc_pkg::COUNT_W-1:0]  refused_sum;
    logic [lldc_pkg::WCOUNT_W-1:0] reg_workers;
    logic [lldc_pkg::LOAD_W-1:0]   reg_slots;

    lldc_pkg::out_item_t results_due [$];
    int                  mismatches = 0;
    int                  quiet_cycles = 0;
    int                  gap_odds = 0;
    int                  stall_odds = 0;

    least_loaded_capped_dispatcher uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // number of entries in use, zero acting as one and clipped at the table size
    function automatic int active_workers();
        if (reg_workers == '0)
            return 1;
        if (reg_workers > lldc_pkg::MAX_WORKERS)
            return lldc_pkg::MAX_WORKERS;
        return int'(reg_workers);
    endfunction

    // register write side effects, shrinking retires the entries above the new count
    function automatic void apply_register(input logic [lldc_pkg::CFG_IDX_W-1:0] idx,
                                           input logic [lldc_pkg::CFG_DATA_W-1:0] value);
        int span;
        if (idx == lldc_pkg::CFG_WORKER_COUNT)
        begin
            reg_workers = value[lldc_pkg::WCOUNT_W-1:0];
            span = active_workers();
            for (int i = span; i < lldc_pkg::MAX_WORKERS; i++)
            begin
                if (live_of[i])
                begin
                    live_of[i] = 1'b0;
                    if (live_sum != '0)
                        live_sum = live_sum - 1'b1;
                end
                load_of[i] = '0;
            end
        end
        else
        begin
            reg_slots = value[lldc_pkg::LOAD_W-1:0];
        end
    endfunction

    // result of one item, updating the predicted worker table
    function automatic lldc_pkg::out_item_t next_dispatch_result(input lldc_pkg::in_item_t it);
        lldc_pkg::out_item_t         r;
        int                          span;
        int                          best;
        logic [lldc_pkg::LOAD_W-1:0] cap;
        span = active_workers();
        cap = (reg_slots == '0) ? 10'd1 : reg_slots;
        r = '0;
        r.chosen_worker = it.worker_id;
        r.status = lldc_pkg::ST_OK;
        if (it.op == lldc_pkg::OP_DISPATCH)
        begin
            // least loaded live worker below the cap, lowest index on ties
            best = -1;
            for (int i = 0; i < span; i++)
                if (live_of[i] && load_of[i] < cap && (best < 0 || load_of[i] < load_of[best]))
                    best = i;
            if (best >= 0)
            begin
                load_of[best] = load_of[best] + 1'b1;
                if (granted_sum != '1)
                    granted_sum = granted_sum + 1'b1;
                r.granted = 1'b1;
                r.chosen_worker = 8'(best);
                r.worker_load = load_of[best];
            end
            else
            begin
                if (refused_sum != '1)
                    refused_sum = refused_sum + 1'b1;
                r.chosen_worker = '0;
                r.status = lldc_pkg::ST_BUSY;
            end
        end
        else if (int'(it.worker_id) >= span)
        begin
            r.status = lldc_pkg::ST_NOT_LIVE;
        end
        else
        begin
            case (it.op)
                lldc_pkg::OP_COMPLETE:
                begin
                    if (!live_of[it.worker_id])
                        r.status = lldc_pkg::ST_NOT_LIVE;
                    else
                    begin
                        if (it.done_count > load_of[it.worker_id])
                        begin
                            load_of[it.worker_id] = '0;
                            r.status = lldc_pkg::ST_CLAMPED;
                        end
                        else
                            load_of[it.worker_id] = load_of[it.worker_id] - it.done_count;
                        r.worker_load = load_of[it.worker_id];
                    end
                end
                lldc_pkg::OP_START:
                begin
                    if (!live_of[it.worker_id])
                    begin
                        live_of[it.worker_id] = 1'b1;
                        live_sum = live_sum + 1'b1;
                    end
                    r.worker_load = load_of[it.worker_id];
                end
                lldc_pkg::OP_LOST:
                begin
                    if (!live_of[it.worker_id])
                        r.status = lldc_pkg::ST_NOT_LIVE;
                    else
                    begin
                        live_of[it.worker_id] = 1'b0;
                        load_of[it.worker_id] = '0;
                        if (live_sum != '0)
                            live_sum = live_sum - 1'b1;
                    end
                end
                default:
                begin
                    r.status = lldc_pkg::ST_OK;
                end
            endcase
        end
        // listener gate over the entries in use
        for (int i = 0; i < span; i++)
            if (live_of[i] && load_of[i] < cap)
                r.accept_open = 1'b1;
        r.live_workers = live_sum;
        r.total_dispatched = granted_sum;
        r.total_rejected = refused_sum;
        return r;
    endfunction

    // random item, mostly aimed at workers in use with small reports
    function automatic lldc_pkg::in_item_t random_item(input int span);
        lldc_pkg::in_item_t it;
        int unsigned        pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            it.op = lldc_pkg::OP_DISPATCH;
        else if (pick < 65)
            it.op = lldc_pkg::OP_COMPLETE;
        else if (pick < 85)
            it.op = lldc_pkg::OP_START;
        else
            it.op = lldc_pkg::OP_LOST;
        if ($urandom_range(0, 9) == 0)
            it.worker_id = 8'($urandom);
        else
            it.worker_id = 8'($urandom_range(0, span - 1));
        if ($urandom_range(0, 7) == 0)
            it.done_count = 9'($urandom);
        else
            it.done_count = 9'($urandom_range(0, 3));
        return it;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // present one item, hold it until taken, then record its result
    task automatic push_item(input lldc_pkg::in_item_t it, input logic typed,
                             input lldc_pkg::out_item_t want);
        lldc_pkg::out_item_t predicted;
        in_valid <= 1'b1;
        in_data <= it;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        predicted = next_dispatch_result(it);
        results_due.push_back(typed ? want : predicted);
    endtask

    // random sender gap
    task automatic maybe_pause();
        if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
    endtask

    // drain every pending result so a register can be written safely
    task automatic settle();
        in_valid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [lldc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [lldc_pkg::CFG_DATA_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        apply_register(idx, value);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // result checker
    always @(posedge clk)
    begin
        lldc_pkg::out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (results_due.size() == 0)
            begin
                $error("result with no item pending: %p", out_data);
                mismatches++;
            end
            else
            begin
                want = results_due.pop_front();
                check_field("granted", 32'(want.granted), 32'(out_data.granted));
                check_field("chosen_worker", 32'(want.chosen_worker),
                            32'(out_data.chosen_worker));
                check_field("status", 32'(want.status), 32'(out_data.status));
                check_field("worker_load", 32'(want.worker_load), 32'(out_data.worker_load));
                check_field("accept_open", 32'(want.accept_open), 32'(out_data.accept_open));
                check_field("live_workers", 32'(want.live_workers),
                            32'(out_data.live_workers));
                check_field("total_dispatched", want.total_dispatched,
                            out_data.total_dispatched);
                check_field("total_rejected", want.total_rejected, out_data.total_rejected);
            end
        end
    end

    // hang detection
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || !rst_n)
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("** least_loaded_capped_dispatcher: FAILED **");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // receiver stall bursts
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // stimulus
    initial
    begin
        int span;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        for (int i = 0; i < lldc_pkg::MAX_WORKERS; i++)
        begin
            load_of[i] = '0;
            live_of[i] = 1'b0;
        end
        live_sum = '0;
        granted_sum = '0;
        refused_sum = '0;
        reg_workers = 9'd1;
        reg_slots = 10'd1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        gap_odds = 6;
        stall_odds = 6;
        for (int r = 0; r < PLAN_ROWS; r++)
        begin
            if (PLAN[r].kind == ROW_CFG)
            begin
                settle();
                write_reg(PLAN[r].reg_index, PLAN[r].reg_value);
            end
            else
            begin
                push_item(PLAN[r].item, PLAN[r].typed, PLAN[r].want);
                maybe_pause();
            end
        end

        // random phases, no idling in the last one
        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            write_reg(lldc_pkg::CFG_SLOT_LIMIT, PHASE_LIST[p].slots);
            write_reg(lldc_pkg::CFG_WORKER_COUNT, PHASE_LIST[p].workers);
            span = active_workers();
            if (p == PHASES - 1)
            begin
                gap_odds = 0;
                stall_odds = 0;
            end
            else
            begin
                case ($urandom_range(0, 2))
                    0: gap_odds = 0;
                    1: gap_odds = 12;
                    default: gap_odds = 3;
                endcase
                case ($urandom_range(0, 2))
                    0: stall_odds = 0;
                    1: stall_odds = 12;
                    default: stall_odds = 3;
                endcase
            end
            repeat (PHASE_LIST[p].items)
            begin
                push_item(random_item(span), 1'b0, '0);
                maybe_pause();
            end
        end

        // drain and let the block go quiet
        in_valid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("** least_loaded_capped_dispatcher: PASSED **");
        else
            $display("** least_loaded_capped_dispatcher: FAILED **");
        $finish;
    end

endmodule

FILE: filelist.f
sv/lldc_pkg.sv
sv/lldc_load_ram.sv
sv/least_loaded_capped_dispatcher.sv
bench/least_loaded_capped_dispatcher_test.sv
